// ===== hw/rtl/ray_grid_histogram_assert.svh =====
// Assertion macros shared by the ray grid histogram RTL.
// Expects clk and rst_n in the including scope; no other dependencies.
`ifndef RAY_GRID_HISTOGRAM_ASSERT_SVH
`define RAY_GRID_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define RGH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RGH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rgh_pkg.sv =====
// Package for the ray grid histogram: field widths, register map, codes,
// control structs and the sequencer state type. No dependencies.
package rgh_pkg;

  localparam int HW_W    = 31;
  localparam int SCALE_W = 31;
  localparam int GRID_W  = 9;
  localparam int POS_W   = 32;
  localparam int BIN_W   = 32;
  localparam int CNT_W   = 48;
  localparam int RC_W    = 8;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic [BIN_W-1:0] BIN_MAX = '1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_HALF_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCALE       = 2'd1;
  localparam logic [1:0] REG_GRID_IN_USE = 2'd2;

  localparam logic [HW_W-1:0]    HALF_WIDTH_RST  = 31'd65536;
  localparam logic [SCALE_W-1:0] SCALE_RST       = 31'd65536;
  localparam logic [GRID_W-1:0]  GRID_IN_USE_RST = 9'd256;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [HW_W-1:0]    half_width;
    logic [SCALE_W-1:0] scale;
    logic [GRID_W-1:0]  grid_in_use;
  } cfg_t;

  typedef struct packed {
    logic ld_sum;
    logic ld_prod;
    logic ld_idx;
  } idx_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_IDX,
    ST_READ,
    ST_WRITE
  } state_t;

endpackage

// ===== hw/rtl/rgh_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module rgh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/rgh_cfg.sv =====
// APB-style register file for half_width, scale and grid_in_use.
// Depends on rgh_pkg.
module rgh_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rgh_pkg::CFG_AW-1:0] paddr,
  input  logic [rgh_pkg::CFG_DW-1:0] pwdata,
  output logic [rgh_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output rgh_pkg::cfg_t              cfg
);

  rgh_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        rgh_pkg::REG_HALF_WIDTH:  cfg_nxt.half_width  = pwdata[rgh_pkg::HW_W-1:0];
        rgh_pkg::REG_SCALE:       cfg_nxt.scale       = pwdata[rgh_pkg::SCALE_W-1:0];
        rgh_pkg::REG_GRID_IN_USE: cfg_nxt.grid_in_use = pwdata[rgh_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_width  <= rgh_pkg::HALF_WIDTH_RST;
      cfg_r.scale       <= rgh_pkg::SCALE_RST;
      cfg_r.grid_in_use <= rgh_pkg::GRID_IN_USE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rgh_pkg::REG_HALF_WIDTH:  prdata = rgh_pkg::CFG_DW'(cfg_r.half_width);
      rgh_pkg::REG_SCALE:       prdata = rgh_pkg::CFG_DW'(cfg_r.scale);
      rgh_pkg::REG_GRID_IN_USE: prdata = rgh_pkg::CFG_DW'(cfg_r.grid_in_use);
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/rgh_idx.sv =====
// Bin index unit: offset by half width, Q16.16 multiply by scale, floor and
// clamp to the last grid line. Three enabled stages. Depends on rgh_pkg.
module rgh_idx #(
  parameter int IDX_W = 8
) (
  input  logic                         clk,
  input  rgh_pkg::idx_ctl_t            ctl,
  input  logic [rgh_pkg::POS_W-1:0]    pos,
  input  logic [rgh_pkg::HW_W-1:0]     half_width,
  input  logic [rgh_pkg::SCALE_W-1:0]  scale,
  input  logic [IDX_W-1:0]             last,
  output logic [IDX_W-1:0]             idx
);

  localparam int SUM_W  = rgh_pkg::POS_W;
  localparam int PROD_W = SUM_W + rgh_pkg::SCALE_W;
  localparam int HI_W   = PROD_W - 32;

  logic [SUM_W:0]    sum_w;
  logic [PROD_W-1:0] prod_w;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [HI_W-1:0]   prod_hi_r, prod_hi_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // only meaningful when |pos| < half_width, then the sum fits in 32 bits
  assign sum_w  = {pos[SUM_W-1], pos} + (SUM_W+1)'(half_width);
  assign prod_w = PROD_W'(sum_r) * PROD_W'(scale);

  always_comb begin
    sum_nxt     = ctl.ld_sum  ? sum_w[SUM_W-1:0]     : sum_r;
    prod_hi_nxt = ctl.ld_prod ? prod_w[PROD_W-1:32]  : prod_hi_r;
    idx_nxt     = idx_r;
    if (ctl.ld_idx) begin
      if (prod_hi_r > HI_W'(last)) begin
        idx_nxt = last;
      end else begin
        idx_nxt = prod_hi_r[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    prod_hi_r <= prod_hi_nxt;
    idx_r     <= idx_nxt;
  end

  assign idx = idx_r;

endmodule

// ===== hw/rtl/ray_grid_histogram.sv =====
// Ray grid histogram: bins Q16.16 ray positions into a square grid of counts.
// Results cannot be stalled. An accepted item steps through ST_MUL, ST_IDX,
// ST_READ and ST_WRITE; out_valid is registered from ST_WRITE. busy is high
// in all four, so the multiply and the read-modify-write of the bin memory
// through its single read port end before a new item. Reset: a clearing pass
// writes zero to all GRID_SIZE*GRID_SIZE bins, one a cycle; busy stays high.
`include "ray_grid_histogram_assert.svh"

module ray_grid_histogram #(
  parameter int GRID_SIZE = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic signed [31:0]          in_pos_x,
  input  logic signed [31:0]          in_pos_y,
  input  logic [7:0]                  in_read_row,
  input  logic [7:0]                  in_read_col,
  // result channel
  output logic                        out_valid,
  output logic                        out_in_range,
  output logic [7:0]                  out_bin_row,
  output logic [7:0]                  out_bin_col,
  output logic [31:0]                 out_bin_count,
  output logic [47:0]                 out_total_rays,
  output logic [47:0]                 out_excluded_rays,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int IDX_W  = $clog2(GRID_SIZE);
  localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BIN_W  = rgh_pkg::BIN_W;
  localparam int CNT_W  = rgh_pkg::CNT_W;
  localparam int RC_W   = rgh_pkg::RC_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  rgh_pkg::cfg_t cfg;

  rgh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Last usable grid line: grid_in_use clamped to 1..GRID_SIZE, minus one.
  logic [IDX_W-1:0] last;

  always_comb begin
    if (cfg.grid_in_use == '0) begin
      last = '0;
    end else if (32'(cfg.grid_in_use) > 32'(GRID_SIZE)) begin
      last = IDX_W'(GRID_SIZE - 1);
    end else begin
      last = IDX_W'(cfg.grid_in_use - 9'd1);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  rgh_pkg::state_t   state_r, state_nxt;
  rgh_pkg::idx_ctl_t idx_ctl;
  logic              accept;
  logic              clearing;
  logic              bin_wr;
  logic              finish;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rgh_pkg::ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = rgh_pkg::ST_IDLE;
        end
      end
      rgh_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = rgh_pkg::ST_MUL;
        end
      end
      rgh_pkg::ST_MUL:   state_nxt = rgh_pkg::ST_IDX;
      rgh_pkg::ST_IDX:   state_nxt = rgh_pkg::ST_READ;
      rgh_pkg::ST_READ:  state_nxt = rgh_pkg::ST_WRITE;
      rgh_pkg::ST_WRITE: state_nxt = rgh_pkg::ST_IDLE;
      default:           state_nxt = rgh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = 1'b1;
    clearing        = 1'b0;
    finish          = 1'b0;
    idx_ctl.ld_sum  = 1'b0;
    idx_ctl.ld_prod = 1'b0;
    idx_ctl.ld_idx  = 1'b0;
    unique case (state_r)
      rgh_pkg::ST_CLEAR: clearing = 1'b1;
      rgh_pkg::ST_IDLE: begin
        busy           = 1'b0;
        idx_ctl.ld_sum = start;
      end
      rgh_pkg::ST_MUL:   idx_ctl.ld_prod = 1'b1;
      rgh_pkg::ST_IDX:   idx_ctl.ld_idx  = 1'b1;
      rgh_pkg::ST_READ:  ;
      rgh_pkg::ST_WRITE: finish = 1'b1;
      default:           ;
    endcase
  end

  assign clr_cnt_nxt = clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rgh_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Command capture and range check
  // ---------------------------------------------------------------------
  logic [32:0]     abs_x, abs_y;
  logic            rng_w;
  logic            op_r, op_nxt;
  logic            rng_r, rng_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic [RC_W-1:0] rd_row_r, rd_row_nxt;
  logic [RC_W-1:0] rd_col_r, rd_col_nxt;

  assign abs_x = in_pos_x[31] ? 33'd0 - {in_pos_x[31], in_pos_x} : {1'b0, in_pos_x};
  assign abs_y = in_pos_y[31] ? 33'd0 - {in_pos_y[31], in_pos_y} : {1'b0, in_pos_y};
  // on the boundary counts as outside
  assign rng_w = (abs_x < 33'(cfg.half_width)) && (abs_y < 33'(cfg.half_width));

  always_comb begin
    op_nxt     = op_r;
    rng_nxt    = rng_r;
    rd_ok_nxt  = rd_ok_r;
    rd_row_nxt = rd_row_r;
    rd_col_nxt = rd_col_r;
    if (accept) begin
      op_nxt     = in_opcode;
      rng_nxt    = rng_w;
      rd_ok_nxt  = (32'(in_read_row) < 32'(GRID_SIZE)) && (32'(in_read_col) < 32'(GRID_SIZE));
      rd_row_nxt = in_read_row;
      rd_col_nxt = in_read_col;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    rng_r    <= rng_nxt;
    rd_ok_r  <= rd_ok_nxt;
    rd_row_r <= rd_row_nxt;
    rd_col_r <= rd_col_nxt;
  end

  // ---------------------------------------------------------------------
  // Row (from x) and column (from y) index units
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0] idx_row, idx_col;

  rgh_idx #(.IDX_W(IDX_W)) u_idx_row (
    .clk        (clk),
    .ctl        (idx_ctl),
    .pos        (in_pos_x),
    .half_width (cfg.half_width),
    .scale      (cfg.scale),
    .last       (last),
    .idx        (idx_row)
  );

  rgh_idx #(.IDX_W(IDX_W)) u_idx_col (
    .clk        (clk),
    .ctl        (idx_ctl),
    .pos        (in_pos_y),
    .half_width (cfg.half_width),
    .scale      (cfg.scale),
    .last       (last),
    .idx        (idx_col)
  );

  // ---------------------------------------------------------------------
  // Bin memory: read in ST_READ, modify and write back in ST_WRITE.
  // One item at a time, so no overlap on the same bin.
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]  row_sel, col_sel;
  logic [ADDR_W-1:0] bin_addr;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BIN_W-1:0]  ram_wdata;
  logic [BIN_W-1:0]  ram_rdata;
  logic [BIN_W-1:0]  bin_inc;
  logic              ram_we;

  assign row_sel  = (op_r == rgh_pkg::OP_READ) ? IDX_W'(rd_row_r) : idx_row;
  assign col_sel  = (op_r == rgh_pkg::OP_READ) ? IDX_W'(rd_col_r) : idx_col;
  assign bin_addr = ADDR_W'(row_sel) * ADDR_W'(GRID_SIZE) + ADDR_W'(col_sel);

  // saturating increment
  assign bin_inc = (ram_rdata == rgh_pkg::BIN_MAX) ? ram_rdata : ram_rdata + 1'b1;

  assign bin_wr    = finish && (op_r == rgh_pkg::OP_ADD) && rng_r;
  assign ram_we    = clearing || bin_wr;
  assign ram_waddr = clearing ? clr_cnt_r : bin_addr;
  assign ram_wdata = clearing ? '0 : bin_inc;

  rgh_ram #(.WIDTH(BIN_W), .DEPTH(DEPTH)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (bin_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Ray counters and result registers
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] excl_r, excl_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic             orng_r, orng_nxt;
  logic [RC_W-1:0]  orow_r, orow_nxt;
  logic [RC_W-1:0]  ocol_r, ocol_nxt;
  logic [BIN_W-1:0] ocnt_r, ocnt_nxt;

  always_comb begin
    total_nxt  = total_r;
    excl_nxt   = excl_r;
    ovalid_nxt = finish;
    orng_nxt   = orng_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    ocnt_nxt   = ocnt_r;
    if (finish) begin
      orng_nxt = 1'b0;
      orow_nxt = '0;
      ocol_nxt = '0;
      ocnt_nxt = '0;
      if (op_r == rgh_pkg::OP_READ) begin
        orow_nxt = rd_row_r;
        ocol_nxt = rd_col_r;
        ocnt_nxt = rd_ok_r ? ram_rdata : '0;
      end else begin
        total_nxt = total_r + 1'b1;
        if (rng_r) begin
          orng_nxt = 1'b1;
          orow_nxt = RC_W'(idx_row);
          ocol_nxt = RC_W'(idx_col);
          ocnt_nxt = bin_inc;
        end else begin
          excl_nxt = excl_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      excl_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      total_r  <= total_nxt;
      excl_r   <= excl_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    orng_r <= orng_nxt;
    orow_r <= orow_nxt;
    ocol_r <= ocol_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign out_valid         = ovalid_r;
  assign out_in_range      = orng_r;
  assign out_bin_row       = orow_r;
  assign out_bin_col       = ocol_r;
  assign out_bin_count     = ocnt_r;
  assign out_total_rays    = total_r;
  assign out_excluded_rays = excl_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `RGH_ASSERT_NOW(a_bin_wr_only_binned, ram_we && !clearing, op_r == rgh_pkg::OP_ADD && rng_r, "bin written for read or excluded beat")
  `RGH_ASSERT_NOW(a_binned_nonzero, out_valid && out_in_range, out_bin_count != '0, "binned ray reports zero count")
  `RGH_ASSERT_NEXT(a_strobe_one_cycle, out_valid, !out_valid, "result strobe longer than one cycle")
  `RGH_ASSERT_NEXT(a_accept_starts_mul, accept, state_r == rgh_pkg::ST_MUL && busy, "accepted beat did not enter multiply")

endmodule

// ===== tb/sv/ray_grid_histogram_checker.sv =====
// Checker for the ray grid histogram: watches the command, result and APB
// ports, keeps its own copy of bins, counters and registers, and scores beats.
// Depends on rgh_pkg for widths, register indexes, opcodes and reset values.
`timescale 1ns / 1ps

module ray_grid_histogram_checker
  import rgh_pkg::*;
#(
  parameter int GRID_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic                in_opcode,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic [7:0]          in_read_row,
  input  logic [7:0]          in_read_col,
  input  logic                out_valid,
  input  logic                out_in_range,
  input  logic [7:0]          out_bin_row,
  input  logic [7:0]          out_bin_col,
  input  logic [31:0]         out_bin_count,
  input  logic [47:0]         out_total_rays,
  input  logic [47:0]         out_excluded_rays,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready,
  output int                  pending,
  output int                  fail_count
);

  typedef struct packed {
    logic              in_range;
    logic [RC_W-1:0]   bin_row;
    logic [RC_W-1:0]   bin_col;
    logic [BIN_W-1:0]  bin_count;
    logic [CNT_W-1:0]  total_rays;
    logic [CNT_W-1:0]  excluded_rays;
  } bin_beat_t;

  logic [BIN_W-1:0] bin_counts [GRID_SIZE*GRID_SIZE];
  logic [CNT_W-1:0] rays_seen;
  logic [CNT_W-1:0] rays_dropped;
  cfg_t             regs;
  bin_beat_t        expected_beats [$];
  int               errors = 0;

  assign fail_count = errors;

  // grid line of one in-range coordinate: floor((c + hw) * scale / 2^32), clamped to the last line
  function automatic int grid_line(longint signed c);
    longint unsigned sum, prod, idx, last;
    int lim;
    lim = regs.grid_in_use;
    if (lim < 1) lim = 1;
    if (lim > GRID_SIZE) lim = GRID_SIZE;
    sum  = c + longint'(regs.half_width);
    prod = sum * longint'(regs.scale);
    idx  = prod >> 32;
    last = lim - 1;
    return (idx > last) ? int'(last) : int'(idx);
  endfunction

  function automatic bin_beat_t histogram_step(logic op, logic signed [31:0] x,
                                               logic signed [31:0] y,
                                               logic [7:0] rr, logic [7:0] rc);
    bin_beat_t b;
    longint signed xs, ys, ax, ay, hw;
    int r, c, a;
    logic [BIN_W-1:0] v;
    b = '0;
    if (op == OP_READ) begin
      b.bin_row = rr;
      b.bin_col = rc;
      if (rr < GRID_SIZE && rc < GRID_SIZE) b.bin_count = bin_counts[rr*GRID_SIZE + rc];
    end else begin
      xs = x;
      ys = y;
      ax = (xs < 0) ? -xs : xs;
      ay = (ys < 0) ? -ys : ys;
      hw = longint'(regs.half_width);
      rays_seen = rays_seen + 1'b1;
      if (ax < hw && ay < hw) begin
        r = grid_line(xs);
        c = grid_line(ys);
        a = r*GRID_SIZE + c;
        v = bin_counts[a];
        if (v != BIN_MAX) v = v + 1'b1;
        bin_counts[a] = v;
        b.in_range  = 1'b1;
        b.bin_row   = r[RC_W-1:0];
        b.bin_col   = c[RC_W-1:0];
        b.bin_count = v;
      end else begin
        rays_dropped = rays_dropped + 1'b1;
      end
    end
    b.total_rays    = rays_seen;
    b.excluded_rays = rays_dropped;
    return b;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bin_beat_t want;
    logic [31:0] reg_value;
    if (!rst_n) begin
      for (int i = 0; i < GRID_SIZE*GRID_SIZE; i++) bin_counts[i] = '0;
      rays_seen    = '0;
      rays_dropped = '0;
      regs.half_width  = HALF_WIDTH_RST;
      regs.scale       = SCALE_RST;
      regs.grid_in_use = GRID_IN_USE_RST;
      expected_beats.delete();
    end else begin
      if (out_valid) begin
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result beat with nothing expected", $realtime);
        end else begin
          want = expected_beats.pop_front();
          check_field("in_range", want.in_range, out_in_range);
          check_field("bin_row", want.bin_row, out_bin_row);
          check_field("bin_col", want.bin_col, out_bin_col);
          check_field("bin_count", want.bin_count, out_bin_count);
          check_field("total_rays", want.total_rays, out_total_rays);
          check_field("excluded_rays", want.excluded_rays, out_excluded_rays);
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_HALF_WIDTH:  regs.half_width  = pwdata[HW_W-1:0];
            REG_SCALE:       regs.scale       = pwdata[SCALE_W-1:0];
            REG_GRID_IN_USE: regs.grid_in_use = pwdata[GRID_W-1:0];
            default: ;
          endcase
        end else begin
          reg_value = '0;
          case (paddr[3:2])
            REG_HALF_WIDTH:  reg_value[HW_W-1:0]    = regs.half_width;
            REG_SCALE:       reg_value[SCALE_W-1:0] = regs.scale;
            REG_GRID_IN_USE: reg_value[GRID_W-1:0]  = regs.grid_in_use;
            default: ;
          endcase
          if (paddr[3:2] != 2'd3) check_field("prdata", reg_value, prdata);
        end
      end
      if (start && !busy)
        expected_beats.push_back(histogram_step(in_opcode, in_pos_x, in_pos_y,
                                                in_read_row, in_read_col));
    end
    pending <= expected_beats.size();
  end

endmodule

// ===== tb/sv/tb_ray_grid_histogram.sv =====
// Testbench top for ray_grid_histogram: clock, reset, command and APB stimulus.
// Scoring lives in ray_grid_histogram_checker; types come from rgh_pkg.
`timescale 1ns / 1ps

module tb_ray_grid_histogram;
  import rgh_pkg::*;

  localparam logic [1:0]  REG_UNUSED = 2'd3;     // index past the register map
  localparam logic [31:0] ONE_Q      = 32'd65536; // 1.0 in Q16.16
  localparam logic [30:0] HW_MAX     = 31'h7FFF_FFFF;
  localparam int          PHASES     = 14;
  localparam int          PER_PHASE  = 82;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic               in_opcode   = OP_ADD;
  logic signed [31:0] in_pos_x    = '0;
  logic signed [31:0] in_pos_y    = '0;
  logic [7:0]         in_read_row = '0;
  logic [7:0]         in_read_col = '0;
  logic               out_valid;
  logic               out_in_range;
  logic [7:0]         out_bin_row;
  logic [7:0]         out_bin_col;
  logic [31:0]        out_bin_count;
  logic [47:0]        out_total_rays;
  logic [47:0]        out_excluded_rays;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [3:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  int pending;
  int fail_count;

  // what the stimulus has done, for the closing summary
  int sent_items = 0;
  int ray_items  = 0;
  int read_items = 0;
  int reg_writes = 0;

  // current setting as the stimulus sees it, to aim rays and reads
  logic [30:0]        cur_hw  = HALF_WIDTH_RST;
  int                 cur_lim = 256;
  logic signed [31:0] last_x  = '0;
  logic signed [31:0] last_y  = '0;

  ray_grid_histogram u_dut (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_pos_x, .in_pos_y, .in_read_row, .in_read_col,
    .out_valid, .out_in_range, .out_bin_row, .out_bin_col, .out_bin_count,
    .out_total_rays, .out_excluded_rays,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ray_grid_histogram_checker u_checker (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_pos_x, .in_pos_y, .in_read_row, .in_read_col,
    .out_valid, .out_in_range, .out_bin_row, .out_bin_col, .out_bin_count,
    .out_total_rays, .out_excluded_rays,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pending, .fail_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, ample for the clearing pass and about 1170 items plus sender gaps.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // sender gap rate: 19% for the first stretch, then 58%, then back to back
  function automatic int gap_pct();
    if (sent_items < 390) return 19;
    if (sent_items < 780) return 58;
    return 0;
  endfunction

  // One command beat. start stays high from one beat to the next when no gap
  // is drawn, so it is never dropped and raised in the same step.
  task automatic send_item(logic op, logic [31:0] x, logic [31:0] y,
                           logic [7:0] rr, logic [7:0] rc);
    while ($urandom_range(99) < gap_pct()) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_opcode   <= op;
    in_pos_x    <= x;
    in_pos_y    <= y;
    in_read_row <= rr;
    in_read_col <= rc;
    do @(posedge clk); while (busy);
    sent_items++;
    if (op == OP_READ) read_items++;
    else ray_items++;
  endtask

  // Block idle: no beat owed and busy low (also covers the clearing pass).
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic apb_access(logic wr, logic [1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write all three registers and read each back. Upper bits of the words
  // may carry junk; the block keeps only the register width.
  task automatic set_config(logic [31:0] hw_word, logic [31:0] sc_word,
                            logic [31:0] grid_word);
    int g;
    apb_access(1'b1, REG_HALF_WIDTH, hw_word);
    apb_access(1'b1, REG_SCALE, sc_word);
    apb_access(1'b1, REG_GRID_IN_USE, grid_word);
    apb_access(1'b0, REG_HALF_WIDTH, '0);
    apb_access(1'b0, REG_SCALE, '0);
    apb_access(1'b0, REG_GRID_IN_USE, '0);
    reg_writes += 3;
    cur_hw = hw_word[HW_W-1:0];
    g = grid_word[GRID_W-1:0];
    cur_lim = (g < 1) ? 1 : (g > 256) ? 256 : g;
  endtask

  // scale that spreads the accepted square over lim bins
  function automatic logic [31:0] matched_scale(logic [30:0] hw, int lim);
    longint unsigned s;
    s = (longint'(lim / 2) << 32) / longint'(hw);
    if (s < 1) s = 1;
    if (s > HW_MAX) s = HW_MAX;
    return s[31:0];
  endfunction

  // Mostly inside the square, some on and just past the edge, some raw noise.
  function automatic logic [31:0] pick_coord(logic [30:0] hw);
    int m;
    longint v;
    m = $urandom_range(99);
    if (m < 70 && hw != 0) v = longint'($urandom) % longint'(hw);
    else if (m < 78)       v = hw;
    else if (m < 85)       v = longint'(hw) + $urandom_range(1, 16);
    else                   return $urandom;
    if ($urandom_range(1)) v = -v;
    return v[31:0];
  endfunction

  task automatic run_random(int n);
    logic [7:0] rr, rc;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        // half the reads aim at the grid in use, where binned rays land
        if ($urandom_range(1)) begin
          rr = $urandom_range(cur_lim - 1);
          rc = $urandom_range(cur_lim - 1);
        end else begin
          rr = $urandom_range(255);
          rc = $urandom_range(255);
        end
        send_item(OP_READ, $urandom, $urandom, rr, rc);
      end else begin
        // repeat the last ray now and then: back-to-back hits on one bin
        if ($urandom_range(9) != 0) begin
          last_x = pick_coord(cur_hw);
          last_y = pick_coord(cur_hw);
        end
        send_item(OP_ADD, last_x, last_y, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int guard;
    logic [31:0] hw_w, sc_w, g_w;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // reset setting: hw 1.0, scale 1.0 puts the origin in bin (1,1)
    send_item(OP_ADD, 32'd0, 32'd0, 8'd0, 8'd0);
    send_item(OP_READ, 32'd0, 32'd0, 8'd1, 8'd1);

    // hw 1.0 over the full 256 grid
    wait_idle();
    set_config(ONE_Q, matched_scale(ONE_Q[30:0], 256), 32'd256);
    send_item(OP_ADD, 32'd0, 32'd0, 8'd0, 8'd0);
    send_item(OP_ADD, 32'd0, 32'd0, 8'd0, 8'd0);
    send_item(OP_ADD, 32'd0, 32'd0, 8'd0, 8'd0);
    send_item(OP_ADD, ONE_Q - 1, -(ONE_Q - 1), 8'd0, 8'd0);
    send_item(OP_ADD, -(ONE_Q - 1), ONE_Q - 1, 8'd0, 8'd0);
    send_item(OP_ADD, ONE_Q, 32'd0, 8'd0, 8'd0);          // on the edge: out
    send_item(OP_ADD, 32'd0, -ONE_Q, 8'd0, 8'd0);
    send_item(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 8'd0);
    send_item(OP_ADD, 32'h8000_0000, 32'd0, 8'd0, 8'd0);
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'd1, 8'd0, 8'd0);
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 8'd0);
    send_item(OP_READ, 32'd0, 32'd0, 8'd128, 8'd128);
    send_item(OP_READ, 32'd0, 32'd0, 8'd255, 8'd0);
    send_item(OP_READ, 32'd0, 32'd0, 8'd0, 8'd255);
    send_item(OP_READ, 32'd0, 32'd0, 8'd255, 8'd255);
    send_item(OP_READ, 32'd0, 32'd0, 8'd0, 8'd0);
    send_item(OP_READ, 32'd0, 32'd0, 8'd127, 8'd127);

    // zero half width: nothing gets binned, store is untouched
    wait_idle();
    set_config(32'd0, ONE_Q, 32'd256);
    send_item(OP_ADD, 32'd0, 32'd0, 8'd0, 8'd0);
    send_item(OP_ADD, 32'd1, 32'hFFFF_FFFF, 8'd0, 8'd0);
    send_item(OP_READ, 32'd0, 32'd0, 8'd128, 8'd128);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_config({1'b0, HW_MAX}, 32'd1, 32'd2);
        1: set_config(32'd1, {1'b0, HW_MAX}, 32'd256);
        2: set_config(32'd0, ONE_Q, 32'd256);
        3: set_config(32'd4 << 16, ONE_Q, 32'd8);
        4: set_config({1'b0, HW_MAX}, {1'b0, HW_MAX}, 32'd511);   // clamps to 256
        5: set_config(ONE_Q, matched_scale(ONE_Q[30:0], 256), 32'd0);  // clamps to 1
        6: set_config(32'd1 << 20, matched_scale(31'd1 << 20, 256), 32'd257);
        default: begin
          case ($urandom_range(4))
            0:       g_w = $urandom_range(0, 511);
            1, 2:    g_w = $urandom_range(2, 16);
            default: g_w = $urandom_range(2, 256);
          endcase
          if ($urandom_range(1)) hw_w = $urandom_range(1, 32'h0010_0000);
          else hw_w = $urandom_range(1, HW_MAX);
          if ($urandom_range(3) == 0) sc_w = $urandom_range(1, HW_MAX);
          else begin
            cur_lim = (g_w < 1) ? 1 : (g_w > 256) ? 256 : g_w;
            sc_w = matched_scale(hw_w[30:0], (cur_lim < 2) ? 2 : cur_lim);
          end
          // junk above the register widths
          hw_w[31]    = $urandom_range(1);
          sc_w[31]    = $urandom_range(1);
          g_w[31:9]   = $urandom;
          set_config(hw_w, sc_w, g_w);
        end
      endcase
      if (p == 0) apb_access(1'b1, REG_UNUSED, 32'hFFFF_FFFF);  // ignored index
      run_random(PER_PHASE);
    end

    // drain: wait for every owed beat, then for anything stray
    start <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 5000);
    repeat (8) @(posedge clk);

    if (pending != 0) $display("%0d result beats never arrived", pending);
    $display("Sent %0d beats: %0d rays, %0d bin reads, over %0d register writes",
             sent_items, ray_items, read_items, reg_writes);
    $display("Settings spanned zero/min/max half width and scale, grids 0..511");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rgh_pkg.sv
hw/rtl/rgh_ram.sv
hw/rtl/rgh_cfg.sv
hw/rtl/rgh_idx.sv
hw/rtl/ray_grid_histogram.sv
tb/sv/ray_grid_histogram_checker.sv
tb/sv/tb_ray_grid_histogram.sv
